/* src/stcp_pkg.sv */
// Shared types and helpers for the stable three-class partition unit.
// Holds the byte class encoding, the buffer entry layout and the classifier.
// No dependencies.
package stcp_pkg;

  typedef enum logic [1:0] {
    CLS_LOWER = 2'd0,
    CLS_UPPER = 2'd1,
    CLS_OTHER = 2'd2
  } class_e;

  typedef struct packed {
    class_e     cls;
    logic [7:0] ch;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  localparam logic [7:0] LowerFirst = 8'h61;
  localparam logic [7:0] LowerLast  = 8'h7a;
  localparam logic [7:0] UpperFirst = 8'h41;
  localparam logic [7:0] UpperLast  = 8'h5a;

  function automatic class_e classify(input logic [7:0] b);
    class_e c;
    if (b inside {[LowerFirst:LowerLast]}) begin
      c = CLS_LOWER;
    end else if (b inside {[UpperFirst:UpperLast]}) begin
      c = CLS_UPPER;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

endpackage

/* src/stcp_if.sv */
// Valid/ready channel interfaces for the partition unit's input and output items.
// No dependencies.
interface stcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_final;

  modport source (output valid, output char_in, output is_final, input ready);
  modport sink   (input valid, input char_in, input is_final, output ready);
endinterface

interface stcp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_out;
  logic       overflowed;

  modport source (output valid, output char_out, output last_out, output overflowed,
                  input ready);
  modport sink   (input valid, input char_out, input last_out, input overflowed,
                  output ready);
endinterface

/* src/stable_three_class_partition_unit.sv */
// Stable three-class partition unit: lowercase, then uppercase, then other bytes.
// Input items are taken back to back while the descriptor queue has room; each stored
// sequence drains by one read per byte per class pass on the single buffer read port.
// The first result is read from the buffer only after the final item is accepted.
// Two buffer banks let the next sequence load while the previous one drains.
// Reset clears the control state at once; the buffer, descriptor slots and output data are not cleared.
module stable_three_class_partition_unit import stcp_pkg::*; #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stcp_in_if.sink    in_i,
  stcp_out_if.source out_o
);

  localparam int unsigned AddrW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CntW  = $clog2(MAX_LEN + 1);
  localparam int unsigned DescW = CntW + 2;
  localparam int unsigned Depth = 2 ** (AddrW + 1);

  logic              ram_we;
  logic [AddrW:0]    ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic              ram_re;
  logic [AddrW:0]    ram_raddr;
  logic [EntryW-1:0] ram_rdata;

  logic              push;
  logic [DescW-1:0]  push_desc;
  logic              full;
  logic              desc_valid;
  logic [DescW-1:0]  desc;
  logic              desc_pop;

  stcp_front #(
    .MaxLen (MAX_LEN),
    .AddrW  (AddrW),
    .CntW   (CntW),
    .DescW  (DescW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .push_o      (push),
    .push_desc_o (push_desc),
    .full_i      (full)
  );

  stcp_queue #(
    .Width (DescW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .pop_i       (desc_pop),
    .valid_o     (desc_valid),
    .data_o      (desc),
    .full_o      (full)
  );

  stcp_ram #(
    .Width (EntryW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  stcp_back #(
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_bank_i  (desc[DescW-1]),
    .desc_cnt_i   (desc[DescW-2:1]),
    .desc_drop_i  (desc[0]),
    .desc_pop_o   (desc_pop),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_o        (out_o)
  );

endmodule

/* src/stcp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module stcp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/stcp_front.sv */
// Front end: accepts input items, classifies each byte and writes it into the
// current buffer bank. Depends on stcp_pkg and stcp_in_if.
module stcp_front import stcp_pkg::*; #(
  parameter int unsigned MaxLen = 64,
  parameter int unsigned AddrW  = 6,
  parameter int unsigned CntW   = 7,
  parameter int unsigned DescW  = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  stcp_in_if.sink           in_i,
  output logic              ram_we_o,
  output logic [AddrW:0]    ram_waddr_o,
  output logic [EntryW-1:0] ram_wdata_o,
  output logic              push_o,
  output logic [DescW-1:0]  push_desc_o,
  input  logic              full_i
);

  logic            bank_q, bank_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            drop_q, drop_d;
  logic            accept;
  logic            room;
  logic [CntW-1:0] cnt_new;
  logic            drop_new;
  entry_t          entry;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign room       = cnt_q < CntW'(MaxLen);
  assign cnt_new    = room ? cnt_q + CntW'(1) : cnt_q;
  assign drop_new   = drop_q | !room;

  always_comb begin
    entry.cls = classify(in_i.char_in);
    entry.ch  = in_i.char_in;
  end

  assign ram_we_o    = accept && room;
  assign ram_waddr_o = {bank_q, cnt_q[AddrW-1:0]};
  assign ram_wdata_o = entry;
  assign push_o      = accept && in_i.is_final;
  assign push_desc_o = {bank_q, cnt_new, drop_new};

  always_comb begin
    bank_d = bank_q;
    cnt_d  = cnt_q;
    drop_d = drop_q;
    if (accept) begin
      if (in_i.is_final) begin
        bank_d = !bank_q;
        cnt_d  = '0;
        drop_d = 1'b0;
      end else begin
        cnt_d  = cnt_new;
        drop_d = drop_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      bank_q <= bank_d;
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
    end
  end

endmodule

/* src/stcp_queue.sv */
// Two-entry queue of sequence descriptors between the front and back ends.
// No dependencies.
module stcp_queue #(
  parameter int unsigned Width = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o,
  output logic             full_o
);

  logic [Width-1:0] slot_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       fill_q;

  assign valid_o = fill_q != 2'd0;
  assign full_o  = fill_q == 2'd2;
  assign data_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into a full descriptor queue");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !pop_i) else $error("pop from an empty descriptor queue");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3) else $error("descriptor queue fill out of range");
`endif

endmodule

/* src/stcp_back.sv */
// Back end: drains one buffered sequence in three class passes over its bank and
// presents the items in partitioned order. Depends on stcp_pkg and stcp_out_if.
module stcp_back import stcp_pkg::*; #(
  parameter int unsigned AddrW = 6,
  parameter int unsigned CntW  = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              desc_valid_i,
  input  logic              desc_bank_i,
  input  logic [CntW-1:0]   desc_cnt_i,
  input  logic              desc_drop_i,
  output logic              desc_pop_o,
  output logic              ram_re_o,
  output logic [AddrW:0]    ram_raddr_o,
  input  logic [EntryW-1:0] ram_rdata_i,
  stcp_out_if.source        out_o
);

  class_e           pass_q, pass_d;
  class_e           st_pass_q, st_pass_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             done_q, done_d;
  logic             st_v_q, st_v_d;
  logic [CntW-1:0]  emit_q, emit_d;
  logic             ov_q, ov_d;
  logic [7:0]       oc_q, oc_d;
  logic             ol_q, ol_d;
  logic             of_q, of_d;

  entry_t           rd;
  logic             out_free;
  logic             match;
  logic             st_adv;
  logic             load;
  logic             emit_last;
  logic             finish;
  logic             issue;
  logic             idx_last;
  logic [CntW-1:0]  emit_nxt;

  assign rd        = entry_t'(ram_rdata_i);
  assign out_free  = !ov_q || out_o.ready;
  assign match     = rd.cls == st_pass_q;
  assign st_adv    = st_v_q && (!match || out_free);
  assign load      = st_adv && match;
  assign emit_nxt  = emit_q + CntW'(1);
  assign emit_last = emit_nxt == desc_cnt_i;
  assign finish    = load && emit_last;
  assign issue     = desc_valid_i && !done_q && (!st_v_q || st_adv) && !finish;
  assign idx_last  = (CntW'(idx_q) + CntW'(1)) == desc_cnt_i;

  assign desc_pop_o  = finish;
  assign ram_re_o    = issue;
  assign ram_raddr_o = {desc_bank_i, idx_q};

  assign out_o.valid      = ov_q;
  assign out_o.char_out   = oc_q;
  assign out_o.last_out   = ol_q;
  assign out_o.overflowed = of_q;

  always_comb begin
    pass_d    = pass_q;
    st_pass_d = st_pass_q;
    idx_d     = idx_q;
    done_d    = done_q;
    st_v_d    = st_v_q;
    emit_d    = emit_q;
    ov_d      = ov_q;
    oc_d      = oc_q;
    ol_d      = ol_q;
    of_d      = of_q;

    if (out_o.ready) begin
      ov_d = 1'b0;
    end
    if (load) begin
      ov_d   = 1'b1;
      oc_d   = rd.ch;
      ol_d   = emit_last;
      of_d   = desc_drop_i;
      emit_d = emit_nxt;
    end

    if (st_adv) begin
      st_v_d = 1'b0;
    end
    if (issue) begin
      st_v_d    = 1'b1;
      st_pass_d = pass_q;
      if (idx_last) begin
        idx_d = '0;
        case (pass_q)
          CLS_LOWER: pass_d = CLS_UPPER;
          CLS_UPPER: pass_d = CLS_OTHER;
          default:   done_d = 1'b1;
        endcase
      end else begin
        idx_d = idx_q + AddrW'(1);
      end
    end

    if (finish) begin
      pass_d = CLS_LOWER;
      idx_d  = '0;
      done_d = 1'b0;
      st_v_d = 1'b0;
      emit_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= CLS_LOWER;
      idx_q  <= '0;
      done_q <= 1'b0;
      st_v_q <= 1'b0;
      emit_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      pass_q <= pass_d;
      idx_q  <= idx_d;
      done_q <= done_d;
      st_v_q <= st_v_d;
      emit_q <= emit_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_pass_q <= st_pass_d;
    oc_q      <= oc_d;
    ol_q      <= ol_d;
    of_q      <= of_d;
  end

`ifndef NO_ASSERTIONS
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_valid_i |-> emit_q < desc_cnt_i) else $error("more items emitted than stored");
  a_stage_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_v_q |-> desc_valid_i) else $error("read data pending with no sequence in hand");
  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_valid_i |-> desc_cnt_i != '0) else $error("empty sequence queued for drain");
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !ram_re_o) else $error("buffer read after the last pass");
`endif

endmodule

/* tb/sv/tb_stable_three_class_partition_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the stable three-class partition unit.
// Drives byte sequences over the input channel, predicts the reordered output and
// checks every result item; depends on stcp_pkg, the channel interfaces and the RTL.
module tb_stable_three_class_partition_unit;
  import stcp_pkg::*;

  localparam int unsigned SeqCap = 64;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } sorted_byte_t;

  logic clk_i;
  logic rst_ni;

  stcp_in_if  in_ch ();
  stcp_out_if out_ch ();

  stable_three_class_partition_unit #(
    .MAX_LEN (SeqCap)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  logic [7:0]   held_bytes [SeqCap];
  int unsigned  held_count;
  logic         held_dropped;
  sorted_byte_t sorted_q [$];

  int unsigned fail_count;
  int unsigned bytes_sent;
  int unsigned long_hold;
  logic        src_idle_on;
  logic        sink_idle_on;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_in   = 8'h00;
    in_ch.is_final  = 1'b0;
    out_ch.ready    = 1'b0;
    held_count      = 0;
    held_dropped    = 1'b0;
    fail_count      = 0;
    bytes_sent      = 0;
    long_hold       = 0;
    src_idle_on     = 1'b1;
    sink_idle_on    = 1'b1;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic class_e byte_class(input logic [7:0] b);
    class_e c;
    if (b >= LowerFirst && b <= LowerLast) begin
      c = CLS_LOWER;
    end else if (b >= UpperFirst && b <= UpperLast) begin
      c = CLS_UPPER;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

  // Keeps the byte if there is room; on the final byte the held sequence is
  // queued in class order and the sequence state is cleared.
  task automatic absorb_byte(input logic [7:0] ch, input logic fin);
    class_e       order [3];
    sorted_byte_t r;
    int unsigned  emitted;
    order = '{CLS_LOWER, CLS_UPPER, CLS_OTHER};
    if (held_count < SeqCap) begin
      held_bytes[held_count] = ch;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (fin) begin
      emitted = 0;
      foreach (order[k]) begin
        for (int unsigned i = 0; i < held_count; i++) begin
          if (byte_class(held_bytes[i]) == order[k]) begin
            emitted++;
            r.ch   = held_bytes[i];
            r.last = (emitted == held_count);
            r.ovf  = held_dropped;
            sorted_q.push_back(r);
          end
        end
      end
      held_count   = 0;
      held_dropped = 1'b0;
    end
  endtask

  task automatic send_byte(input logic [7:0] ch, input logic fin);
    int unsigned gap;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.char_in  <= ch;
    in_ch.is_final <= fin;
    do begin
      @(posedge clk_i);
    end while (!in_ch.ready);
    absorb_byte(ch, fin);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: b = 8'($urandom_range(LowerFirst, LowerLast));
      1: b = 8'($urandom_range(UpperFirst, UpperLast));
      2: b = 8'($urandom_range(0, 255));
      3: b = 8'($urandom_range(8'h3a, 8'h40));
      default: begin
        case ($urandom_range(0, 5))
          0: b = LowerFirst - 8'd1;
          1: b = LowerLast + 8'd1;
          2: b = UpperFirst - 8'd1;
          3: b = UpperLast + 8'd1;
          4: b = 8'h80;
          default: b = 8'hff;
        endcase
      end
    endcase
    return b;
  endfunction

  task automatic send_sequence(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(pick_byte(), i == len - 1);
    end
  endtask

  task automatic test_class_boundaries();
    logic [7:0] edges [12];
    edges = '{8'h60, 8'h61, 8'h7a, 8'h7b, 8'h40, 8'h41, 8'h5a, 8'h5b,
              8'h00, 8'hff, 8'h7f, 8'h80};
    send_byte(8'h6d, 1'b1);
    foreach (edges[i]) begin
      send_byte(edges[i], i == 11);
    end
    send_byte(8'h71, 1'b0);
    send_byte(8'h78, 1'b1);
    send_byte(8'h4b, 1'b0);
    send_byte(8'h30, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h46, 1'b0);
    send_byte(8'h25, 1'b1);
  endtask

  task automatic test_buffer_full();
    send_sequence(SeqCap);
    send_sequence(SeqCap + 3);
  endtask

  task automatic test_random_sequences();
    int unsigned len;
    while (bytes_sent < 192) begin
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(40, SeqCap + 6);
      end else begin
        len = $urandom_range(1, 16);
      end
      if (len > 192 - bytes_sent) begin
        len = 192 - bytes_sent;
      end
      send_sequence(len);
    end
  endtask

  // The receiver holds off long enough for both banks to fill and the input
  // to stall while the sender keeps offering items.
  task automatic test_output_backpressure();
    src_idle_on = 1'b0;
    long_hold   = 400;
    send_sequence(16);
    send_sequence(16);
    send_sequence(16);
    src_idle_on = 1'b1;
  endtask

  task automatic test_full_rate();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_sequence(1);
    send_sequence(12);
    send_sequence(7);
  endtask

  initial begin : sink_ready
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold > 0) begin
        out_ch.ready <= 1'b0;
        while (long_hold > 0) begin
          @(negedge clk_i);
          long_hold--;
        end
        out_ch.ready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        gap = $urandom_range(1, 16);
        repeat (gap) @(negedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    sorted_byte_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (sorted_q.size() == 0) begin
        $error("unexpected result item: char_out %02h", out_ch.char_out);
        fail_count++;
      end else begin
        want = sorted_q.pop_front();
        if (out_ch.char_out !== want.ch) begin
          $error("char_out: expected %02h, got %02h", want.ch, out_ch.char_out);
          fail_count++;
        end
        if (out_ch.last_out !== want.last) begin
          $error("last_out: expected %0b, got %0b", want.last, out_ch.last_out);
          fail_count++;
        end
        if (out_ch.overflowed !== want.ovf) begin
          $error("overflowed: expected %0b, got %0b", want.ovf, out_ch.overflowed);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_class_boundaries();
    test_buffer_full();
    test_random_sequences();
    test_output_backpressure();
    test_full_rate();
    in_ch.valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (3 * SeqCap) @(posedge clk_i);
    if (sorted_q.size() != 0) begin
      $error("%0d result items never arrived", sorted_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
src/stcp_pkg.sv
src/stcp_if.sv
src/stcp_ram.sv
src/stcp_front.sv
src/stcp_queue.sv
src/stcp_back.sv
src/stable_three_class_partition_unit.sv
tb/sv/tb_stable_three_class_partition_unit.sv
